>>> design/pitch_to_note_quantizer_defines.svh
// Assertion macros for the pitch-to-note quantizer.
// Used by the top level; no other dependencies.
`ifndef PITCH_TO_NOTE_QUANTIZER_DEFINES_SVH
`define PITCH_TO_NOTE_QUANTIZER_DEFINES_SVH

`ifndef SYNTH
// Condition a implies condition b in the same cycle.
`define PNQ_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Condition a implies condition b in the next cycle.
`define PNQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PNQ_ASSERT_NOW(label, clk, rst_n, a, b)
`define PNQ_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

>>> design/pnq_pkg.sv
// Package for the pitch-to-note quantizer: widths, register codes and helpers.
// No dependencies.
package pnq_pkg;

    localparam int DefNumNotes = 88;
    localparam int LogFrac     = 28;
    localparam int FreqW       = 24;
    localparam int RefW        = 17;
    localparam int CfgIdxW     = 2;
    localparam int ExpW        = 5;
    localparam int MantW       = 31;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_REFERENCE_A4 = 2'd0,
        REG_LOWER_LIMIT  = 2'd1,
        REG_UPPER_LIMIT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ExpW-1:0]  e;
        logic [MantW-1:0] m;
    } norm_t;

    // Leading-one search and shift of the mantissa into Q1.30.
    function automatic norm_t normalize(logic [FreqW-1:0] v);
        norm_t res;
        logic [ExpW-1:0] e;
        e = '0;
        for (int i = 0; i < FreqW; i++) begin
            if (v[i]) e = ExpW'(i);
        end
        res.e = e;
        res.m = MantW'({7'd0, v}) << (ExpW'(30) - e);
        return res;
    endfunction

    // Index modulo 12 by conditional subtraction.
    function automatic logic [3:0] mod12(logic [6:0] v);
        logic [6:0] x;
        x = v;
        if (x >= 7'd96) x = x - 7'd96;
        if (x >= 7'd48) x = x - 7'd48;
        if (x >= 7'd24) x = x - 7'd24;
        if (x >= 7'd12) x = x - 7'd12;
        return x[3:0];
    endfunction

endpackage

>>> design/pitch_to_note_quantizer.sv
// Each word passes the input stage, the logarithm and stages A, B and C in order.
// Throughput: one word per cycle; busy stays low, start is taken every cycle.
// The 28 squaring stages of the logarithm set the latency, two multiplies per stage.
// Reset (rst_n, asynchronous, low) clears the valid pipeline and loads register defaults.
// The receiver cannot stall: done marks each result for exactly one cycle.
`include "pitch_to_note_quantizer_defines.svh"

module pitch_to_note_quantizer
    import pnq_pkg::*;
#(
    parameter int NOTE_COUNT = DefNumNotes
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FreqW-1:0]   frequency,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [FreqW-1:0]   cfg_data,
    output logic               done,
    output logic [6:0]         note_num,
    output logic [3:0]         note_class,
    output logic signed [15:0] cents,
    output logic               in_range
);

    localparam int Steps   = LogFrac;
    localparam int Latency = Steps + 5;
    localparam logic [6:0] MaxIdx = 7'(NOTE_COUNT - 1);

    // Configuration registers.
    logic [RefW-1:0]  ref_a4_reg;
    logic [FreqW-1:0] lower_reg;
    logic [FreqW-1:0] upper_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_a4_reg <= RefW'(112640);
            lower_reg  <= FreqW'(5120);
            upper_reg  <= FreqW'(1280000);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_REFERENCE_A4: ref_a4_reg <= cfg_data[RefW-1:0];
                REG_LOWER_LIMIT:  lower_reg  <= cfg_data;
                REG_UPPER_LIMIT:  upper_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Input stage: capture the word, the range check and the zero flag.
    logic             in_valid_reg;
    logic [FreqW-1:0] in_freq_reg;
    logic [RefW-1:0]  in_ref_reg;
    logic             in_zero_reg;
    logic             in_inr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) in_valid_reg <= 1'b0;
        else        in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_freq_reg <= frequency;
        in_ref_reg  <= (ref_a4_reg == '0) ? RefW'(1) : ref_a4_reg;
        in_zero_reg <= (frequency == '0);
        in_inr_reg  <= (frequency > lower_reg) && (frequency < upper_reg);
    end

    // Logarithm pipeline: stage 0 holds the normalized mantissas, each later
    // stage squares them once and shifts one fraction bit in.
    logic [MantW-1:0]  mf_reg   [0:Steps];
    logic [MantW-1:0]  mr_reg   [0:Steps];
    logic [ExpW-1:0]   ef_reg   [0:Steps];
    logic [ExpW-1:0]   er_reg   [0:Steps];
    logic [Steps-1:0]  ff_reg   [0:Steps];
    logic [Steps-1:0]  fr_reg   [0:Steps];
    logic              v_reg    [0:Steps];
    logic              zero_reg [0:Steps];
    logic              inr_reg  [0:Steps];

    norm_t nf_next;
    norm_t nr_next;

    always_comb
    begin
        nf_next = normalize(in_freq_reg);
        nr_next = normalize(FreqW'(in_ref_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg[0] <= 1'b0;
        else        v_reg[0] <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        mf_reg[0]   <= nf_next.m;
        ef_reg[0]   <= nf_next.e;
        mr_reg[0]   <= nr_next.m;
        er_reg[0]   <= nr_next.e;
        ff_reg[0]   <= '0;
        fr_reg[0]   <= '0;
        zero_reg[0] <= in_zero_reg;
        inr_reg[0]  <= in_inr_reg;
    end

    for (genvar k = 1; k <= Steps; k++) begin : g_sq
        logic [2*MantW-1:0] sqf;
        logic [2*MantW-1:0] sqr;
        logic [31:0]        qf;
        logic [31:0]        qr;

        always_comb
        begin
            sqf = mf_reg[k-1] * mf_reg[k-1];
            sqr = mr_reg[k-1] * mr_reg[k-1];
            qf  = sqf[2*MantW-1:30];
            qr  = sqr[2*MantW-1:30];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg[k] <= 1'b0;
            else        v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            mf_reg[k]   <= qf[31] ? qf[31:1] : qf[30:0];
            mr_reg[k]   <= qr[31] ? qr[31:1] : qr[30:0];
            ff_reg[k]   <= {ff_reg[k-1][Steps-2:0], qf[31]};
            fr_reg[k]   <= {fr_reg[k-1][Steps-2:0], qr[31]};
            ef_reg[k]   <= ef_reg[k-1];
            er_reg[k]   <= er_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
            inr_reg[k]  <= inr_reg[k-1];
        end
    end

    // Stage A: log distance to A0 and its multiple by 12.
    logic signed [34:0] d_next;
    logic signed [39:0] t_next;
    logic signed [39:0] t_reg;
    logic               a_valid_reg;
    logic               a_zero_reg;
    logic               a_inr_reg;

    always_comb
    begin
        d_next = $signed({2'b00, ef_reg[Steps], ff_reg[Steps]})
               - $signed({2'b00, er_reg[Steps], fr_reg[Steps]})
               + 35'sd1073741824;
        t_next = (40'(d_next) <<< 3) + (40'(d_next) <<< 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) a_valid_reg <= 1'b0;
        else        a_valid_reg <= v_reg[Steps];
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        a_zero_reg <= zero_reg[Steps];
        a_inr_reg  <= inr_reg[Steps];
    end

    // Stage B: round to the nearest note, clamp, and keep the remainder.
    logic signed [39:0] u_next;
    logic signed [11:0] raw_next;
    logic [6:0]         idx_next;
    logic signed [40:0] r_next;
    logic signed [40:0] r_reg;
    logic [6:0]         idx_reg;
    logic               b_valid_reg;
    logic               b_zero_reg;
    logic               b_inr_reg;

    always_comb
    begin
        u_next   = t_reg + 40'sd134217728;
        raw_next = 12'(u_next >>> LogFrac);
        if (raw_next < 12'sd0)
            idx_next = '0;
        else if (raw_next > $signed({5'd0, MaxIdx}))
            idx_next = MaxIdx;
        else
            idx_next = raw_next[6:0];
        r_next = 41'(t_reg) - $signed({6'd0, idx_next, 28'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) b_valid_reg <= 1'b0;
        else        b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        idx_reg    <= idx_next;
        b_zero_reg <= a_zero_reg;
        b_inr_reg  <= a_inr_reg;
    end

    // Stage C: scale the remainder to 1/16 cent, round and saturate.
    logic signed [52:0] p_next;
    logic signed [24:0] c_next;
    logic signed [15:0] sat_next;
    logic               done_reg;
    logic [6:0]         note_num_reg;
    logic [3:0]         note_class_reg;
    logic signed [15:0] cents_reg;
    logic               in_range_reg;

    always_comb
    begin
        p_next = (53'(r_reg) <<< 10) + (53'(r_reg) <<< 9) + (53'(r_reg) <<< 6)
               + 53'sd134217728;
        c_next = 25'(p_next >>> LogFrac);
        if (c_next > 25'sd32767)
            sat_next = 16'sh7fff;
        else if (c_next < -25'sd32768)
            sat_next = 16'sh8000;
        else
            sat_next = c_next[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= b_valid_reg;
    end

    // A zero frequency has no logarithm: report note zero at the low limit.
    always_ff @(posedge clk)
    begin
        note_num_reg   <= b_zero_reg ? 7'd0 : idx_reg;
        note_class_reg <= b_zero_reg ? 4'd0 : mod12(idx_reg);
        cents_reg      <= b_zero_reg ? 16'sh8000 : sat_next;
        in_range_reg   <= b_inr_reg;
    end

    assign done       = done_reg;
    assign note_num   = note_num_reg;
    assign note_class = note_class_reg;
    assign cents      = cents_reg;
    assign in_range   = in_range_reg;

    // Checks on the result stream.
    `PNQ_ASSERT_NOW(a_done_from_start, clk, rst_n, done, $past(start && !busy, Latency))
    `PNQ_ASSERT_NOW(a_index_clamped, clk, rst_n, done, note_num <= MaxIdx)
    `PNQ_ASSERT_NOW(a_class_legal, clk, rst_n, done, note_class < 4'd12)
    `PNQ_ASSERT_NEXT(a_zero_note, clk, rst_n, b_valid_reg && b_zero_reg, done && note_num == 7'd0)

endmodule
